// File: rtl/core/encoder_speed_moving_average_unit_defines.svh
// Assertion macros shared by the tachometer RTL.
`ifndef ENCODER_SPEED_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define ENCODER_SPEED_MOVING_AVERAGE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESMA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESMA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/esma_pkg.sv
package esma_pkg;

   localparam int HISTORY_DEPTH = 8;

   localparam int TALLY_W  = 16;
   localparam int WINDOW_W = 24;
   localparam int SCALE_W  = 24;
   localparam int SPEED_W  = 40;

   localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int TOTAL_W = SPEED_W + $clog2(HISTORY_DEPTH);
   localparam int STEP_W  = $clog2(TOTAL_W + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE    = 2'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [TALLY_W-1:0]  DEBOUNCE_RESET = 16'd1000;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 24'd100000;
   localparam logic [SCALE_W-1:0]  SCALE_RESET    = 24'd153600;

endpackage

// File: rtl/core/encoder_speed_moving_average_unit.sv
// A tick that does not close a window is absorbed in the cycle it is accepted.
// A window-closing tick runs a bit-serial multiply with the ring update on its last
// step, then a bit-serial division, then an output load that waits while an earlier
// result still holds the output register.
// Throughput: one tick per cycle while idle; a window end blocks input until its result
// is loaded into the output register, longer while an earlier result still waits there.
// Reset is synchronous: control and configuration registers take their reset values and
// the speed history is empty at once (per-entry valid bits), so no clearing pass is needed.
`include "encoder_speed_moving_average_unit_defines.svh"

module encoder_speed_moving_average_unit
   import esma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] pulse_edge, rest zero
   input  logic                   req_tuser,   // [0] operation

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [79:0]            rsp_tdata,   // [39:0] window_speed, [79:40] average_speed

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [TALLY_W-1:0]  debounce_ff, debounce_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;

   logic [TALLY_W-1:0]  tally_ff, tally_in;
   logic [TALLY_W-1:0]  since_ff, since_in;
   logic [WINDOW_W-1:0] elapsed_ff, elapsed_in;

   logic [SPEED_W-1:0]       ring_ff [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     full_ff, full_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;

   logic [TALLY_W-1:0] mul_a_ff, mul_a_in;
   logic [SPEED_W-1:0] acc_ff, acc_in;
   logic [TOTAL_W-1:0] div_sh_ff, div_sh_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                ring_write;
   logic [TALLY_W-1:0]  since_inc;
   logic                edge_counts;
   logic [TALLY_W-1:0]  tally_next;
   logic                window_end;
   logic [SPEED_W-1:0]  old_entry;
   logic [SLOT_W-1:0]   slot_next;
   logic                full_next;
   logic [CNT_W:0]      rem_shift;
   logic                rem_ge;
   logic                out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Tick arithmetic.
   assign since_inc   = (since_ff == '1) ? since_ff : since_ff + 1'b1;
   assign edge_counts = req_tdata[0] && ((since_inc == '1) || (since_inc > debounce_ff));
   assign tally_next  = (edge_counts && (tally_ff != '1)) ? tally_ff + 1'b1 : tally_ff;
   assign window_end  = ({1'b0, elapsed_ff} + 1'b1) >= {1'b0, window_ff};

   // Ring update, done on the last multiply step.
   assign old_entry = valid_ff[slot_ff] ? ring_ff[slot_ff] : '0;
   assign slot_next = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign full_next = full_ff || (slot_ff == SLOT_W'(HISTORY_DEPTH - 1));

   // One restoring division step per cycle.
   assign rem_shift = {rem_ff, div_sh_ff[TOTAL_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      state_in     = state_ff;
      debounce_in  = debounce_ff;
      window_in    = window_ff;
      scale_in     = scale_ff;
      tally_in     = tally_ff;
      since_in     = since_ff;
      elapsed_in   = elapsed_ff;
      valid_in     = valid_ff;
      slot_in      = slot_ff;
      full_in      = full_ff;
      total_in     = total_ff;
      mul_a_in     = mul_a_ff;
      acc_in       = acc_ff;
      div_sh_in    = div_sh_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ring_write   = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            REG_DEBOUNCE: debounce_in = csr_data[TALLY_W-1:0];
            REG_WINDOW:   window_in   = csr_data[WINDOW_W-1:0];
            REG_SCALE:    scale_in    = csr_data[SCALE_W-1:0];
            default:      ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == OP_CLEAR) begin
                  valid_in = '0;
                  slot_in  = '0;
                  full_in  = 1'b0;
                  total_in = '0;
               end else begin
                  since_in = edge_counts ? '0 : since_inc;
                  if (window_end) begin
                     elapsed_in = '0;
                     tally_in   = '0;
                     mul_a_in   = tally_next;
                     acc_in     = '0;
                     step_in    = STEP_W'(TALLY_W - 1);
                     state_in   = S_MUL;
                  end else begin
                     tally_in   = tally_next;
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end
            end
         end
         S_MUL: begin
            // Multiplier bits are taken most significant first.
            acc_in   = {acc_ff[SPEED_W-2:0], 1'b0}
                       + (mul_a_ff[TALLY_W-1] ? SPEED_W'(scale_ff) : '0);
            mul_a_in = {mul_a_ff[TALLY_W-2:0], 1'b0};
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               ring_write = 1'b1;
               total_in   = total_ff - TOTAL_W'(old_entry) + TOTAL_W'(acc_in);
               valid_in[slot_ff] = 1'b1;
               slot_in    = slot_next;
               full_in    = full_next;
               divisor_in = full_next ? CNT_W'(HISTORY_DEPTH) : CNT_W'(slot_next);
               div_sh_in  = total_in;
               rem_in     = '0;
               step_in    = STEP_W'(TOTAL_W - 1);
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            rem_in    = rem_ge ? CNT_W'(rem_shift - {1'b0, divisor_ff}) : CNT_W'(rem_shift);
            div_sh_in = {div_sh_ff[TOTAL_W-2:0], rem_ge};
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {div_sh_ff[SPEED_W-1:0], acc_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         debounce_ff  <= DEBOUNCE_RESET;
         window_ff    <= WINDOW_RESET;
         scale_ff     <= SCALE_RESET;
         tally_ff     <= '0;
         since_ff     <= '1;
         elapsed_ff   <= '0;
         valid_ff     <= '0;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         total_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         debounce_ff  <= debounce_in;
         window_ff    <= window_in;
         scale_ff     <= scale_in;
         tally_ff     <= tally_in;
         since_ff     <= since_in;
         elapsed_ff   <= elapsed_in;
         valid_ff     <= valid_in;
         slot_ff      <= slot_in;
         full_ff      <= full_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_a_ff    <= mul_a_in;
      acc_ff      <= acc_in;
      div_sh_ff   <= div_sh_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
      if (ring_write) begin
         ring_ff[slot_ff] <= acc_in;
      end
   end

   // The number of live entries always matches the write pointer and wrap flag.
   `ESMA_ASSERT_NOW(a_fill_count, 1'b1,
      $countones(valid_ff) == (full_ff ? HISTORY_DEPTH : int'(slot_ff)),
      "ring valid bits disagree with slot pointer")
   // Division never runs with an empty or oversized divisor.
   `ESMA_ASSERT_NOW(a_divisor_range, state_ff == S_DIV,
      (divisor_ff != '0) && (divisor_ff <= CNT_W'(HISTORY_DEPTH)),
      "divisor out of range during division")
   // The partial remainder stays below the divisor between steps.
   `ESMA_ASSERT_NOW(a_rem_bound, state_ff == S_DIV, rem_ff < divisor_ff,
      "partial remainder not reduced")
   // A window result is loaded whenever the output register can take it, and the unit returns to idle.
   `ESMA_ASSERT_NEXT(a_out_load, (state_ff == S_OUT) && out_free,
      rsp_valid_ff && (state_ff == S_IDLE), "result not presented after division")

endmodule

// File: dv/tb_encoder_speed_moving_average_unit.sv
module tb_encoder_speed_moving_average_unit
   import esma_pkg::*;
();

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [SPEED_W-1:0] average_speed;
      logic [SPEED_W-1:0] window_speed;
   } speed_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [0] pulse_edge, rest zero
   logic                   req_tuser;   // [0] operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [79:0]            rsp_tdata;   // [39:0] window_speed, [79:40] average_speed
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Tachometer state as predicted by the testbench.
   logic [TALLY_W-1:0]  debounce_cfg;
   logic [WINDOW_W-1:0] window_cfg;
   logic [SCALE_W-1:0]  scale_cfg;
   logic [TALLY_W-1:0]  pulse_tally;
   logic [TALLY_W-1:0]  since_edge;
   logic [WINDOW_W-1:0] window_elapsed;
   logic [SPEED_W-1:0]  speed_ring [HISTORY_DEPTH];
   int                  ring_slot;
   bit                  ring_full;
   logic [TOTAL_W-1:0]  ring_total;

   speed_result_type expected_speeds[$];
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   hold_request = 0;
   logic          rsp_hold = 1'b0;

   encoder_speed_moving_average_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void clear_history();
      for (int i = 0; i < HISTORY_DEPTH; i++) speed_ring[i] = '0;
      ring_slot = 0;
      ring_full = 1'b0;
      ring_total = '0;
   endfunction

   task automatic reset_tachometer();
      debounce_cfg = DEBOUNCE_RESET;
      window_cfg = WINDOW_RESET;
      scale_cfg = SCALE_RESET;
      pulse_tally = '0;
      since_edge = '1;
      window_elapsed = '0;
      clear_history();
   endtask

   // Advances the predicted state by one item; returns 1 when a window closes.
   function automatic bit advance_tachometer(input logic op, input logic pe,
                                             output speed_result_type res);
      logic [SPEED_W-1:0] speed;
      logic [TOTAL_W-1:0] filled;
      res = '0;
      if (op == OP_CLEAR) begin
         clear_history();
         return 1'b0;
      end
      if (since_edge != '1) since_edge++;
      // A saturated gap counts as longer than any debounce time.
      if (pe && (since_edge == '1 || since_edge > debounce_cfg)) begin
         if (pulse_tally != '1) pulse_tally++;
         since_edge = '0;
      end
      if ({1'b0, window_elapsed} + 25'd1 < {1'b0, window_cfg}) begin
         window_elapsed++;
         return 1'b0;
      end
      window_elapsed = '0;
      speed = SPEED_W'(pulse_tally) * SPEED_W'(scale_cfg);
      pulse_tally = '0;
      ring_total = ring_total - TOTAL_W'(speed_ring[ring_slot]) + TOTAL_W'(speed);
      speed_ring[ring_slot] = speed;
      ring_slot++;
      if (ring_slot == HISTORY_DEPTH) begin
         ring_slot = 0;
         ring_full = 1'b1;
      end
      filled = ring_full ? TOTAL_W'(HISTORY_DEPTH) : TOTAL_W'(ring_slot);
      res.window_speed = speed;
      res.average_speed = SPEED_W'(ring_total / filled);
      return 1'b1;
   endfunction

   task automatic send_item(input logic op, input logic pe);
      speed_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'b0, pe};
      do @(posedge clock); while (!req_tready);
      if (advance_tachometer(op, pe, res)) expected_speeds.push_back(res);
   endtask

   // Waits until every expected result has arrived and the block has gone quiet.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_speeds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEBOUNCE: debounce_cfg = val[TALLY_W-1:0];
         REG_WINDOW:   window_cfg = val[WINDOW_W-1:0];
         REG_SCALE:    scale_cfg = val[SCALE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input logic [SPEED_W-1:0] want,
                                input logic [SPEED_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      speed_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_speeds.size() == 0) begin
            flag_mismatch("unexpected result", '0, rsp_tdata[39:0]);
         end else begin
            want = expected_speeds.pop_front();
            if (rsp_tdata[39:0] !== want.window_speed)
               flag_mismatch("window_speed", want.window_speed, rsp_tdata[39:0]);
            if (rsp_tdata[79:40] !== want.average_speed)
               flag_mismatch("average_speed", want.average_speed, rsp_tdata[79:40]);
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
   initial begin
      forever begin
         wait (hold_request != 0);
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (hold_request) @(posedge clock);
         rsp_hold <= 1'b0;
         hold_request = 0;
      end
   end

   task automatic test_reset_defaults();
      // The first edge after reset counts; the second is inside the debounce time.
      send_item(OP_TICK, 1'b1);
      send_item(OP_TICK, 1'b1);
      send_item(OP_CLEAR, 1'b1);
      send_item(OP_TICK, 1'b0);
      drain_results();
      // Lowering the window below the elapsed count closes it on the next tick.
      write_reg(REG_WINDOW, 24'd1);
      send_item(OP_TICK, 1'b0);
      drain_results();
   endtask

   task automatic test_config_extremes();
      write_reg(REG_DEBOUNCE, 24'd0);
      write_reg(REG_SCALE, 24'hFFFFFF);
      write_reg(REG_WINDOW, 24'd0);
      for (int i = 0; i < 3; i++) send_item(OP_TICK, 1'b1);
      send_item(OP_CLEAR, 1'b0);
      send_item(OP_TICK, 1'b1);
      drain_results();
      write_reg(REG_SCALE, 24'd0);
      write_reg(REG_WINDOW, 24'd2);
      send_item(OP_TICK, 1'b1);
      send_item(OP_TICK, 1'b1);
      drain_results();
      write_reg(REG_SCALE, 24'd1);
      write_reg(REG_DEBOUNCE, 24'd2);
      write_reg(REG_WINDOW, 24'd9);
      write_reg(REG_UNUSED, 24'($urandom));
      for (int i = 0; i < 9; i++) send_item(OP_TICK, 1'b1);
      drain_results();
   endtask

   task automatic test_back_pressure();
      write_reg(REG_WINDOW, 24'd1);
      write_reg(REG_SCALE, 24'($urandom));
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) send_item(OP_TICK, 1'($urandom));
      drain_results();
   endtask

   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] val;
      logic                  op;
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         for (int blk = 0; blk < 5; blk++) begin
            drain_results();
            case ($urandom_range(0, 3))
               0: val = '0;
               1: val = CSR_DATA_W'($urandom_range(1, 4));
               2: val = {8'($urandom), 16'hFFFF};
               default: val = CSR_DATA_W'($urandom);
            endcase
            write_reg(REG_DEBOUNCE, val);
            val = ($urandom_range(0, 99) < 5) ? '0 : CSR_DATA_W'($urandom_range(1, 12));
            write_reg(REG_WINDOW, val);
            case ($urandom_range(0, 3))
               0: val = '0;
               1: val = '1;
               default: val = CSR_DATA_W'($urandom);
            endcase
            write_reg(REG_SCALE, val);
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
            for (int n = 0; n < 50; n++) begin
               op = ($urandom_range(0, 99) < 5) ? OP_CLEAR : OP_TICK;
               send_item(op, 1'($urandom));
            end
         end
      end
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_long_window();
      // With the longest debounce, only a fully saturated gap lets an edge count.
      write_reg(REG_DEBOUNCE, 24'h00FFFF);
      write_reg(REG_WINDOW, 24'hFFFFFF);
      write_reg(REG_SCALE, 24'hFFFFFF);
      for (int i = 0; i < 60; i++) send_item(OP_TICK, 1'b1);
      drain_results();
      write_reg(REG_WINDOW, 24'd1);
      send_item(OP_TICK, 1'b0);
      drain_results();
      // With no debounce, an edge on every tick counts each time.
      write_reg(REG_DEBOUNCE, 24'd0);
      write_reg(REG_WINDOW, 24'hFFFFFF);
      for (int i = 0; i < 60; i++) send_item(OP_TICK, 1'b1);
      drain_results();
      write_reg(REG_WINDOW, 24'd1);
      send_item(OP_TICK, 1'b0);
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset_tachometer();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_config_extremes();
      test_back_pressure();
      test_random_traffic();
      test_long_window();
      drain_results();
      if (mismatch_count == 0 && expected_speeds.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
